[rtl/sfc_pkg.sv]
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared widths, register codes and bundle types of the sphere frustum cull.
// ----------------------------------------------------------------------------
package sfc_pkg;

	localparam int COORD_WIDTH     = 21;
	localparam int COORD_FRAC_BITS = 8;

	localparam int LANE_W     = 21;
	localparam int AXIS_FRAC  = 19;
	localparam int Q_FRAC     = 16;
	localparam int Q_W        = 32;
	localparam int DEPTH_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam int DIFF_W = ((COORD_WIDTH > LANE_W) ? COORD_WIDTH : LANE_W) + 1;
	localparam int PROD_W = DIFF_W + LANE_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int RED    = COORD_FRAC_BITS + AXIS_FRAC - Q_FRAC;
	localparam int AX_W   = SUM_W - RED;
	localparam int RAD_W  = COORD_WIDTH - 1;
	localparam int R16_W  = RAD_W + Q_FRAC - COORD_FRAC_BITS;

	localparam int MAG_W       = 62;
	localparam int HI_W        = MAG_W - Q_W;
	localparam int HI_SAT_BIT  = MAG_W - 1 - Q_FRAC;
	localparam int CMP_W       = 64;

	localparam logic [MAG_W-1:0] SAT_LIM = MAG_W'(1) << (MAG_W - 1);

	localparam logic signed [CMP_W-1:0] DEPTH_MAX =
		$signed((CMP_W'(1) << (DEPTH_W - 1)) - CMP_W'(1));
	localparam logic signed [CMP_W-1:0] DEPTH_MIN = -DEPTH_MAX - CMP_W'(1);

	typedef logic signed [LANE_W-1:0] lane_t;

	localparam lane_t AXIS_ONE = LANE_W'(1) << AXIS_FRAC;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS_X     = 3'd0,
		REG_AXIS_Y     = 3'd1,
		REG_AXIS_Z     = 3'd2,
		REG_CAM_POS    = 3'd3,
		REG_NEAR_FAR   = 3'd4,
		REG_TAN_ASPECT = 3'd5,
		REG_SPHERE_FAC = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		lane_t [2:0]    axis_x;
		lane_t [2:0]    axis_y;
		lane_t [2:0]    axis_z;
		lane_t [2:0]    cam;
		logic [Q_W-1:0] near_d;
		logic [Q_W-1:0] far_d;
		logic [Q_W-1:0] tan_v;
		logic [Q_W-1:0] aspect;
		logic [Q_W-1:0] fac_y;
		logic [Q_W-1:0] fac_x;
	} cfg_t;

	typedef struct packed {
		logic signed [AX_W-1:0]    ay;
		logic signed [AX_W-1:0]    ax;
		logic [MAG_W-1:0]          az_mag;
		logic                      az_neg;
		logic [R16_W-1:0]          rad;
		logic signed [DEPTH_W-1:0] depth;
		logic                      z_out;
	} xf_t;

endpackage

[rtl/sfc_regs.sv]
// ----------------------------------------------------------------------------
// sfc_regs
// Camera and frustum register file, decoded into one bundle.
// ----------------------------------------------------------------------------
module sfc_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output sfc_pkg::cfg_t                    cfg
);
	import sfc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_x <= {LANE_W'(0), LANE_W'(0), AXIS_ONE};
			cfg_q.axis_y <= {LANE_W'(0), AXIS_ONE, LANE_W'(0)};
			cfg_q.axis_z <= {AXIS_ONE, LANE_W'(0), LANE_W'(0)};
			cfg_q.cam    <= '0;
			cfg_q.near_d <= '0;
			cfg_q.far_d  <= '0;
			cfg_q.tan_v  <= '0;
			cfg_q.aspect <= '0;
			cfg_q.fac_y  <= '0;
			cfg_q.fac_x  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_AXIS_X: begin
					cfg_q.axis_x <= cfg_data[3*LANE_W-1:0];
				end
				REG_AXIS_Y: begin
					cfg_q.axis_y <= cfg_data[3*LANE_W-1:0];
				end
				REG_AXIS_Z: begin
					cfg_q.axis_z <= cfg_data[3*LANE_W-1:0];
				end
				REG_CAM_POS: begin
					cfg_q.cam <= cfg_data[3*LANE_W-1:0];
				end
				REG_NEAR_FAR: begin
					cfg_q.near_d <= cfg_data[Q_W-1:0];
					cfg_q.far_d  <= cfg_data[2*Q_W-1:Q_W];
				end
				REG_TAN_ASPECT: begin
					cfg_q.tan_v  <= cfg_data[Q_W-1:0];
					cfg_q.aspect <= cfg_data[2*Q_W-1:Q_W];
				end
				REG_SPHERE_FAC: begin
					cfg_q.fac_y <= cfg_data[Q_W-1:0];
					cfg_q.fac_x <= cfg_data[2*Q_W-1:Q_W];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/sfc_xform.sv]
// ----------------------------------------------------------------------------
// sfc_xform
// Four-stage view transform: camera offset, axis products, dot sums, depth
// saturation and the near/far test.
// ----------------------------------------------------------------------------
module sfc_xform (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sfc_pkg::cfg_t                          cfg,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_x,
	input  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_y,
	input  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_z,
	input  logic [sfc_pkg::RAD_W-1:0]              radius,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output sfc_pkg::xf_t                           xf
);
	import sfc_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic signed [COORD_WIDTH-1:0] ctr [3];
	lane_t [2:0]                   axis_l [3];

	logic signed [DIFF_W-1:0] d_s1 [3];
	logic signed [PROD_W-1:0] p_s2 [3][3];
	logic signed [SUM_W-1:0]  sum_s3 [3];
	logic [R16_W-1:0]         rad_s1, rad_s2, rad_s3;
	xf_t                      xf_s4;

	logic signed [AX_W-1:0]  az_c;
	logic [AX_W-1:0]         az_abs;
	logic signed [CMP_W-1:0] az_w, dep_w, far_lim, near_lim;
	logic signed [DEPTH_W-1:0] depth_c;

	assign ctr[0] = center_x;
	assign ctr[1] = center_y;
	assign ctr[2] = center_z;

	assign axis_l[0] = cfg.axis_x;
	assign axis_l[1] = cfg.axis_y;
	assign axis_l[2] = cfg.axis_z;

	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// offset from camera
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DIFF_W'(ctr[i]) - DIFF_W'($signed(cfg.cam[i]));
			end
			rad_s1 <= R16_W'(radius) << (Q_FRAC - COORD_FRAC_BITS);
		end
	end

	// axis products, one per axis and component
	always_ff @(posedge clk) begin
		if (en2) begin
			for (int a = 0; a < 3; a++) begin
				for (int i = 0; i < 3; i++) begin
					p_s2[a][i] <= PROD_W'(d_s1[i]) * PROD_W'($signed(axis_l[a][i]));
				end
			end
			rad_s2 <= rad_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int a = 0; a < 3; a++) begin
				sum_s3[a] <= SUM_W'(p_s2[a][0]) + SUM_W'(p_s2[a][1]) + SUM_W'(p_s2[a][2]);
			end
			rad_s3 <= rad_s2;
		end
	end

	always_comb begin
		az_c     = AX_W'(sum_s3[2] >>> RED);
		az_abs   = az_c[AX_W-1] ? -az_c : az_c;
		az_w     = CMP_W'(az_c);
		dep_w    = CMP_W'(sum_s3[2] >>> AXIS_FRAC);
		far_lim  = $signed(CMP_W'(cfg.far_d)) + $signed(CMP_W'(rad_s3));
		near_lim = $signed(CMP_W'(cfg.near_d)) - $signed(CMP_W'(rad_s3));
		priority if (dep_w > DEPTH_MAX) begin
			depth_c = DEPTH_W'(DEPTH_MAX);
		end else if (dep_w < DEPTH_MIN) begin
			depth_c = DEPTH_W'(DEPTH_MIN);
		end else begin
			depth_c = DEPTH_W'(dep_w);
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			xf_s4.ay     <= AX_W'(sum_s3[1] >>> RED);
			xf_s4.ax     <= AX_W'(sum_s3[0] >>> RED);
			xf_s4.az_mag <= MAG_W'(az_abs);
			xf_s4.az_neg <= az_c[AX_W-1];
			xf_s4.rad    <= rad_s3;
			xf_s4.depth  <= depth_c;
			xf_s4.z_out  <= (az_w > far_lim) || (az_w < near_lim);
		end
	end

	assign out_valid = v_s4;
	assign xf        = xf_s4;

endmodule

[rtl/sfc_qmul.sv]
// ----------------------------------------------------------------------------
// sfc_qmul
// Two-stage saturating magnitude times Q16.16 multiply, split in two halves.
// ----------------------------------------------------------------------------
module sfc_qmul (
	input  logic                       clk,
	input  logic [1:0]                 en,
	input  logic [sfc_pkg::MAG_W-1:0]  mag,
	input  logic [sfc_pkg::Q_W-1:0]    q,
	output logic [sfc_pkg::MAG_W-1:0]  prod
);
	import sfc_pkg::*;

	logic [MAG_W-1:0]      mag_c;
	logic [2*Q_W-1:0]      p_lo_s1;
	logic [HI_W+Q_W-1:0]   p_hi_s1;
	logic [MAG_W-1:0]      sum_c;
	logic [MAG_W-1:0]      prod_s2;

	assign mag_c = (mag > SAT_LIM) ? SAT_LIM : mag;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_lo_s1 <= (2*Q_W)'(mag_c[Q_W-1:0]) * (2*Q_W)'(q);
			p_hi_s1 <= (HI_W+Q_W)'(mag_c[MAG_W-1:Q_W]) * (HI_W+Q_W)'(q);
		end
	end

	assign sum_c = MAG_W'({p_hi_s1[HI_SAT_BIT-1:0], Q_FRAC'(0)})
		+ MAG_W'(p_lo_s1[2*Q_W-1:Q_FRAC]);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			priority if (|p_hi_s1[HI_W+Q_W-1:HI_SAT_BIT]) begin
				prod_s2 <= SAT_LIM;
			end else if (sum_c > SAT_LIM) begin
				prod_s2 <= SAT_LIM;
			end else begin
				prod_s2 <= sum_c;
			end
		end
	end

	assign prod = prod_s2;

endmodule

[rtl/sfc_bound.sv]
// ----------------------------------------------------------------------------
// sfc_bound
// Five-stage vertical and horizontal bound tests and final verdict register.
// ----------------------------------------------------------------------------
module sfc_bound (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sfc_pkg::cfg_t                      cfg,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  sfc_pkg::xf_t                       xf,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               verdict,
	output logic signed [sfc_pkg::DEPTH_W-1:0] view_depth
);
	import sfc_pkg::*;

	typedef struct packed {
		logic signed [AX_W-1:0]    ay;
		logic signed [AX_W-1:0]    ax;
		logic                      az_neg;
		logic signed [DEPTH_W-1:0] depth;
		logic                      z_out;
	} side_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	side_t side_in, side_s1, side_s2, side_s3, side_s4;
	logic  out_zy_s3, out_zy_s4;

	logic [MAG_W-1:0] bz_mag, bd_y, bd_x, bz2_mag;
	logic [MAG_W-1:0] bd_x_s3, bd_x_s4;

	logic signed [CMP_W-1:0] ay_w, by_w, ax_w, bx_w;
	logic                    out_y, out_x;

	logic                      verdict_s5;
	logic signed [DEPTH_W-1:0] depth_s5;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// depth times tangent, radius times sphere factors
	sfc_qmul u_bz (
		.clk  (clk),
		.en   ({en2, en1}),
		.mag  (xf.az_mag),
		.q    (cfg.tan_v),
		.prod (bz_mag)
	);

	sfc_qmul u_bd_y (
		.clk  (clk),
		.en   ({en2, en1}),
		.mag  (MAG_W'(xf.rad)),
		.q    (cfg.fac_y),
		.prod (bd_y)
	);

	sfc_qmul u_bd_x (
		.clk  (clk),
		.en   ({en2, en1}),
		.mag  (MAG_W'(xf.rad)),
		.q    (cfg.fac_x),
		.prod (bd_x)
	);

	// vertical bound times aspect
	sfc_qmul u_bz2 (
		.clk  (clk),
		.en   ({en4, en3}),
		.mag  (bz_mag),
		.q    (cfg.aspect),
		.prod (bz2_mag)
	);

	assign side_in.ay     = xf.ay;
	assign side_in.ax     = xf.ax;
	assign side_in.az_neg = xf.az_neg;
	assign side_in.depth  = xf.depth;
	assign side_in.z_out  = xf.z_out;

	always_comb begin
		ay_w  = CMP_W'(side_s2.ay);
		by_w  = side_s2.az_neg ? $signed(CMP_W'(bd_y)) - $signed(CMP_W'(bz_mag))
			: $signed(CMP_W'(bd_y)) + $signed(CMP_W'(bz_mag));
		out_y = (ay_w > by_w) || ((ay_w + by_w) < $signed(CMP_W'(0)));

		ax_w  = CMP_W'(side_s4.ax);
		bx_w  = side_s4.az_neg ? $signed(CMP_W'(bd_x_s4)) - $signed(CMP_W'(bz2_mag))
			: $signed(CMP_W'(bd_x_s4)) + $signed(CMP_W'(bz2_mag));
		out_x = (ax_w > bx_w) || ((ax_w + bx_w) < $signed(CMP_W'(0)));
	end

	always_ff @(posedge clk) begin
		if (en1) side_s1 <= side_in;
		if (en2) side_s2 <= side_s1;
		if (en3) begin
			side_s3   <= side_s2;
			out_zy_s3 <= side_s2.z_out || out_y;
			bd_x_s3   <= bd_x;
		end
		if (en4) begin
			side_s4   <= side_s3;
			out_zy_s4 <= out_zy_s3;
			bd_x_s4   <= bd_x_s3;
		end
		if (en5) begin
			verdict_s5 <= out_zy_s4 || out_x;
			depth_s5   <= side_s4.depth;
		end
	end

	assign out_valid  = v_s5;
	assign verdict    = verdict_s5;
	assign view_depth = depth_s5;

endmodule

[rtl/sphere_frustum_cull.sv]
// ----------------------------------------------------------------------------
// sphere_frustum_cull: each request passes through sfc_xform and then sfc_bound
// throughput one sphere per cycle while the output is not stalled, set by the nine-stage valid/ready pipeline
// a stalled output backs up stage by stage, bubbles are squeezed out
// reset clears all valid bits and loads unit axes, other config registers zero
// ----------------------------------------------------------------------------
module sphere_frustum_cull (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [sfc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [sfc_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_x,
	input  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_y,
	input  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_z,
	input  logic [sfc_pkg::RAD_W-1:0]              radius,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   verdict,
	output logic signed [sfc_pkg::DEPTH_W-1:0]     view_depth
);
	import sfc_pkg::*;

	cfg_t cfg;
	xf_t  xf;
	logic xf_valid, xf_ready;

	sfc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfc_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.center_x  (center_x),
		.center_y  (center_y),
		.center_z  (center_z),
		.radius    (radius),
		.out_valid (xf_valid),
		.out_ready (xf_ready),
		.xf        (xf)
	);

	sfc_bound u_bound (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (xf_valid),
		.in_ready   (xf_ready),
		.xf         (xf),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.verdict    (verdict),
		.view_depth (view_depth)
	);

	// a free output slot must reach back to the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while output slot free");

	a_boundary_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!xf_valid || xf_ready) |-> in_ready)
		else $error("transform stalled while bound stage accepts");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("result presented right after reset");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: sphere frustum cull testbench
// Streams bounding spheres through the culling pipeline under zero, saturated,
// random and camera-like setups. Each verdict and view depth is predicted in
// fixed point when the request is taken, and results are checked in order
// while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	import sfc_pkg::*;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
		logic signed [COORD_WIDTH-1:0] cz;
		logic [RAD_W-1:0]              rad;
	} sphere_t;

	typedef struct packed {
		logic                      verdict;
		logic signed [DEPTH_W-1:0] view_depth;
	} cull_t;

	typedef enum int {MODE_ZERO, MODE_ONES, MODE_CAMERA, MODE_NOISE} cfg_mode_t;

	localparam logic VERDICT_INSIDE  = 1'b0;
	localparam logic VERDICT_OUTSIDE = 1'b1;

	localparam longint unsigned SAT_MAG = 64'd1 << 61;
	localparam logic [63:0] ALL_ONES    = '1;
	localparam logic [63:0] LANES_MASK  = (64'd1 << (3 * LANE_W)) - 64'd1;
	localparam longint UNIT_AXIS = longint'(1) << AXIS_FRAC;
	localparam longint LANE_HI   = (longint'(1) << (LANE_W - 1)) - 1;
	localparam longint LANE_LO   = -(longint'(1) << (LANE_W - 1));
	localparam longint COORD_HI  = (longint'(1) << (COORD_WIDTH - 1)) - 1;
	localparam longint COORD_LO  = -(longint'(1) << (COORD_WIDTH - 1));
	localparam longint RAD_HI    = (longint'(1) << RAD_W) - 1;
	localparam longint DEPTH_HI  = (longint'(1) << (DEPTH_W - 1)) - 1;
	localparam longint DEPTH_LO  = -(longint'(1) << (DEPTH_W - 1));
	localparam longint ONE       = longint'(1) << COORD_FRAC_BITS;
	localparam int DEPTH_SHIFT   = COORD_FRAC_BITS + AXIS_FRAC - Q_FRAC;

	localparam int PHASE_COUNT   = 12;
	localparam int PHASE_SPHERES = 90;
	localparam int STALL_LIMIT   = 2000;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic signed [COORD_WIDTH-1:0] center_x = '0;
	logic signed [COORD_WIDTH-1:0] center_y = '0;
	logic signed [COORD_WIDTH-1:0] center_z = '0;
	logic [RAD_W-1:0]            radius = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic                        verdict;
	logic signed [DEPTH_W-1:0]   view_depth;

	logic [63:0] cam_cfg [7];
	sphere_t     pending_spheres [$];
	cull_t       expected_culls [$];
	sphere_t     next_sphere;
	cull_t       want_cull;
	int          send_gap = 0;
	logic        send_calm = 1'b0;
	int          recv_gap = 0;
	int          recv_draw;
	logic        recv_calm = 1'b0;
	int          results_seen = 0;
	int          cull_errors = 0;
	int          stall_cycles = 0;

	sphere_frustum_cull dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.center_x   (center_x),
		.center_y   (center_y),
		.center_z   (center_z),
		.radius     (radius),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.verdict    (verdict),
		.view_depth (view_depth)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint axis_lane(input logic [63:0] packed_v, input int idx);
		lane_t v;
		v = packed_v[LANE_W*idx +: LANE_W];
		return longint'(v);
	endfunction

	function automatic logic [63:0] pack_lanes(input longint a, input longint b, input longint c);
		lane_t la, lb, lc;
		la = LANE_W'(a);
		lb = LANE_W'(b);
		lc = LANE_W'(c);
		return {1'b0, lc, lb, la};
	endfunction

	function automatic longint axis_dot(input longint a, input longint b, input longint c,
		input logic [63:0] axis);
		return a * axis_lane(axis, 0) + b * axis_lane(axis, 1) + c * axis_lane(axis, 2);
	endfunction

	function automatic longint unsigned scale_q16(input longint unsigned mag, input logic [31:0] q);
		logic [127:0] prod;
		prod = ({64'd0, mag} * {96'd0, q}) >> Q_FRAC;
		return (prod > SAT_MAG) ? SAT_MAG : prod[63:0];
	endfunction

	function automatic longint scale_q16_signed(input longint v, input logic [31:0] q);
		longint unsigned mag, scaled;
		if (v < 0)
			mag = -v;
		else
			mag = v;
		if (mag > SAT_MAG)
			mag = SAT_MAG;
		scaled = scale_q16(mag, q);
		return (v < 0) ? -longint'(scaled) : longint'(scaled);
	endfunction

	function automatic cull_t predict_cull(input logic signed [COORD_WIDTH-1:0] cx,
		input logic signed [COORD_WIDTH-1:0] cy, input logic signed [COORD_WIDTH-1:0] cz,
		input logic [RAD_W-1:0] rad);
		longint ox, oy, oz, zsum, depth, az, ay, ax, r, near_q, far_q, bz, bd;
		logic [63:0] tan_asp, factors;
		cull_t res;
		ox = longint'(cx) - axis_lane(cam_cfg[REG_CAM_POS], 0);
		oy = longint'(cy) - axis_lane(cam_cfg[REG_CAM_POS], 1);
		oz = longint'(cz) - axis_lane(cam_cfg[REG_CAM_POS], 2);
		r = {44'd0, rad};
		r = r << (Q_FRAC - COORD_FRAC_BITS);
		tan_asp = cam_cfg[REG_TAN_ASPECT];
		factors = cam_cfg[REG_SPHERE_FAC];
		near_q = {32'd0, cam_cfg[REG_NEAR_FAR][31:0]};
		far_q = {32'd0, cam_cfg[REG_NEAR_FAR][63:32]};

		zsum = axis_dot(ox, oy, oz, cam_cfg[REG_AXIS_Z]);
		depth = zsum >>> AXIS_FRAC;
		if (depth > DEPTH_HI)
			depth = DEPTH_HI;
		if (depth < DEPTH_LO)
			depth = DEPTH_LO;
		az = zsum >>> DEPTH_SHIFT;

		res.verdict = VERDICT_INSIDE;
		if (az > far_q + r || az < near_q - r) begin
			res.verdict = VERDICT_OUTSIDE;
		end else begin
			ay = axis_dot(ox, oy, oz, cam_cfg[REG_AXIS_Y]) >>> DEPTH_SHIFT;
			bd = scale_q16(r, factors[31:0]);
			bz = scale_q16_signed(az, tan_asp[31:0]);
			if (ay > bz + bd || ay < -bz - bd) begin
				res.verdict = VERDICT_OUTSIDE;
			end else begin
				ax = axis_dot(ox, oy, oz, cam_cfg[REG_AXIS_X]) >>> DEPTH_SHIFT;
				bz = scale_q16_signed(bz, tan_asp[63:32]);
				bd = scale_q16(r, factors[63:32]);
				if (ax > bz + bd || ax < -bz - bd)
					res.verdict = VERDICT_OUTSIDE;
			end
		end
		res.view_depth = depth[DEPTH_W-1:0];
		return res;
	endfunction

	function automatic longint signed_spread(input int half);
		return longint'($urandom_range(0, 2 * half)) - half;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(input longint v);
		if (v > COORD_HI)
			return COORD_WIDTH'(COORD_HI);
		if (v < COORD_LO)
			return COORD_WIDTH'(COORD_LO);
		return COORD_WIDTH'(v);
	endfunction

	function automatic sphere_t make_sphere(input longint x, input longint y, input longint z,
		input longint r);
		sphere_t s;
		s.cx = COORD_WIDTH'(x);
		s.cy = COORD_WIDTH'(y);
		s.cz = COORD_WIDTH'(z);
		s.rad = RAD_W'(r);
		return s;
	endfunction

	function automatic sphere_t sphere_near_camera(input int spread);
		sphere_t s;
		s.cx = clamp_coord(axis_lane(cam_cfg[REG_CAM_POS], 0) + signed_spread(spread));
		s.cy = clamp_coord(axis_lane(cam_cfg[REG_CAM_POS], 1) + signed_spread(spread));
		s.cz = clamp_coord(axis_lane(cam_cfg[REG_CAM_POS], 2) + signed_spread(spread));
		if ($urandom_range(0, 7) == 0)
			s.rad = RAD_W'($urandom);
		else
			s.rad = RAD_W'($urandom_range(0, spread));
		return s;
	endfunction

	function automatic logic [63:0] unit_axis(input int pick);
		longint v;
		v = $urandom_range(0, 1) ? -UNIT_AXIS : UNIT_AXIS;
		return pack_lanes(pick == 0 ? v : 0, pick == 1 ? v : 0, pick == 2 ? v : 0);
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		cam_cfg[idx] = (idx <= REG_CAM_POS) ? (value & LANES_MASK) : value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_config(input logic [63:0] ax, input logic [63:0] ay,
		input logic [63:0] az, input logic [63:0] cam, input logic [63:0] near_far,
		input logic [63:0] tan_asp, input logic [63:0] factors);
		write_reg(REG_AXIS_X, ax);
		write_reg(REG_AXIS_Y, ay);
		write_reg(REG_AXIS_Z, az);
		write_reg(REG_CAM_POS, cam);
		write_reg(REG_NEAR_FAR, near_far);
		write_reg(REG_TAN_ASPECT, tan_asp);
		write_reg(REG_SPHERE_FAC, factors);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_spheres.size() != 0 || in_valid || expected_culls.size() != 0);
	endtask

	// request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
			send_calm <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_culls.push_back(predict_cull(center_x, center_y, center_z, radius));
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_spheres.size() != 0) begin
					next_sphere = pending_spheres.pop_front();
					in_valid <= 1'b1;
					center_x <= next_sphere.cx;
					center_y <= next_sphere.cy;
					center_z <= next_sphere.cz;
					radius <= next_sphere.rad;
					send_gap <= send_calm ? 0 : $urandom_range(0, 4);
					if ($urandom_range(0, 39) == 0)
						send_calm <= !send_calm;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
			recv_calm <= 1'b0;
		end else if (out_valid && out_ready) begin
			results_seen++;
			if (expected_culls.size() == 0) begin
				cull_errors++;
				if (cull_errors <= 10)
					$display("result %0d unexpected: verdict %0b depth %0d",
						results_seen, verdict, view_depth);
			end else begin
				want_cull = expected_culls.pop_front();
				if (want_cull.verdict !== verdict || want_cull.view_depth !== view_depth) begin
					cull_errors++;
					if (cull_errors <= 10)
						$display("result %0d: expected verdict %0b depth %0d, got verdict %0b depth %0d",
							results_seen, want_cull.verdict, want_cull.view_depth,
							verdict, view_depth);
				end
			end
			recv_draw = recv_calm ? 0 : $urandom_range(0, 4);
			if (recv_draw == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				recv_gap <= recv_draw - 1;
			end
			if ($urandom_range(0, 39) == 0)
				recv_calm <= !recv_calm;
		end else if (!out_ready) begin
			if (recv_gap == 0)
				out_ready <= 1'b1;
			else
				recv_gap <= recv_gap - 1;
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		int ph, n, spread, p0, p1;
		cfg_mode_t mode;
		sphere_t item;
		logic [31:0] near_q, far_q;

		cam_cfg[REG_AXIS_X] = pack_lanes(UNIT_AXIS, 0, 0);
		cam_cfg[REG_AXIS_Y] = pack_lanes(0, UNIT_AXIS, 0);
		cam_cfg[REG_AXIS_Z] = pack_lanes(0, 0, UNIT_AXIS);
		cam_cfg[REG_CAM_POS] = '0;
		cam_cfg[REG_NEAR_FAR] = '0;
		cam_cfg[REG_TAN_ASPECT] = '0;
		cam_cfg[REG_SPHERE_FAC] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setup: zero far, tangent and factors
		pending_spheres.push_back(make_sphere(0, 0, 0, 0));
		pending_spheres.push_back(make_sphere(0, 0, ONE, 0));
		pending_spheres.push_back(make_sphere(0, 0, -ONE, 0));
		pending_spheres.push_back(make_sphere(0, 0, -ONE, ONE));
		pending_spheres.push_back(make_sphere(ONE, 0, 0, 0));
		pending_spheres.push_back(make_sphere(0, -ONE, 0, 0));
		pending_spheres.push_back(make_sphere(0, ONE, 0, ONE));
		pending_spheres.push_back(make_sphere(COORD_HI, COORD_HI, COORD_HI, RAD_HI));
		pending_spheres.push_back(make_sphere(COORD_LO, COORD_LO, COORD_LO, 0));
		pending_spheres.push_back(make_sphere(0, 0, 0, RAD_HI));
		pending_spheres.push_back(make_sphere(COORD_LO, COORD_HI, 0, 1));
		wait_drained();

		// largest axes and offsets: depth and bound saturation
		load_config(pack_lanes(LANE_HI, LANE_HI, LANE_HI), pack_lanes(LANE_HI, LANE_HI, LANE_HI),
			pack_lanes(LANE_HI, LANE_HI, LANE_HI), pack_lanes(LANE_LO, LANE_LO, LANE_LO),
			{32'hFFFF_FFFF, 32'h0}, ALL_ONES, ALL_ONES);
		pending_spheres.push_back(make_sphere(COORD_HI, COORD_HI, COORD_HI, 0));
		pending_spheres.push_back(make_sphere(COORD_LO, COORD_LO, COORD_LO, 0));
		pending_spheres.push_back(make_sphere(COORD_HI, COORD_LO, COORD_LO, RAD_HI));
		pending_spheres.push_back(make_sphere(0, 0, 0, RAD_HI));
		wait_drained();

		write_reg(REG_AXIS_Z, pack_lanes(LANE_LO, LANE_LO, LANE_LO));
		@(negedge clk);
		pending_spheres.push_back(make_sphere(COORD_HI, COORD_HI, COORD_HI, RAD_HI));
		pending_spheres.push_back(make_sphere(COORD_HI, COORD_HI, COORD_HI, 0));
		pending_spheres.push_back(make_sphere(COORD_LO, COORD_LO, COORD_LO, RAD_HI));
		wait_drained();

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			if (ph == 0)
				mode = MODE_ZERO;
			else if (ph == 1)
				mode = MODE_ONES;
			else if (ph % 4 == 3)
				mode = MODE_NOISE;
			else
				mode = MODE_CAMERA;

			case (mode)
				MODE_ZERO: begin
					load_config('0, '0, '0, '0, '0, '0, '0);
				end
				MODE_ONES: begin
					load_config(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
						ALL_ONES);
				end
				MODE_NOISE: begin
					load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
						{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
						{$urandom, $urandom});
				end
				default: begin
					p0 = $urandom_range(0, 2);
					p1 = (p0 + 1 + $urandom_range(0, 1)) % 3;
					near_q = $urandom_range(0, 4 << Q_FRAC);
					far_q = near_q + $urandom_range(8 << Q_FRAC, 150 << Q_FRAC);
					load_config(unit_axis(p0), unit_axis(p1), unit_axis(3 - p0 - p1),
						pack_lanes(signed_spread(1 << 18), signed_spread(1 << 18),
							signed_spread(1 << 18)),
						{far_q, near_q},
						{32'($urandom_range(32768, 163840)), 32'($urandom_range(16384, 131072))},
						{32'($urandom_range(65536, 131072)), 32'($urandom_range(65536, 131072))});
				end
			endcase

			for (n = 0; n < PHASE_SPHERES; n++) begin
				case ($urandom_range(0, 2))
					0: spread = 64;
					1: spread = 4096;
					default: spread = 32768;
				endcase
				if ((mode == MODE_CAMERA && $urandom_range(0, 4) != 0) ||
					(mode != MODE_CAMERA && $urandom_range(0, 3) == 0)) begin
					item = sphere_near_camera(spread);
				end else begin
					item.cx = COORD_WIDTH'($urandom);
					item.cy = COORD_WIDTH'($urandom);
					item.cz = COORD_WIDTH'($urandom);
					item.rad = RAD_W'($urandom);
				end
				pending_spheres.push_back(item);
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (cull_errors == 0 && expected_culls.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
